// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/plh_pkg.sv
package plh_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned LIST_MAX  = 64;
	localparam int unsigned CQ_DEPTH  = 2;
	localparam int unsigned OQ_DEPTH  = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_APPEND = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ELEM   = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_INSERT,
		K_DELETE,
		K_APPEND,
		K_BOUNDS,
		K_FULL
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SHIFT,
		B_PUT,
		B_LIST,
		B_ONE
	} bstate_t;

	typedef struct packed {
		kind_t              kind;
		logic [6:0]         pos;
		logic signed [31:0] value;
		logic               list;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] element;
		logic [5:0]         slot;
		logic               last;
	} res_t;

endpackage

// File: src/positional_list_insert_delete_unit.sv
// Positional list unit: an ordered store of up to DEPTH signed words.
// Input channel (push/full): one beat carries opcode, position, value, batch_end.
//   A beat is taken when push is high and full is low; full only reflects a
//   two-entry command queue, so beats are taken while the store is busy.
// Result channel (empty/pop): the oldest result sits on status/element/slot/last
//   while empty is low and leaves on a clock with pop high.
// Each insert, delete or batch-ending append lists the store, slot 0 first, at
// most LIST_MAX entries, last set on the final beat; an empty store gives one
// empty-listing beat. Errors give one beat; an append without batch_end and
// opcode 3 give none. The sequencer takes a command from the command queue when
// idle and works on one item at a time: it takes it, moves entries and drains
// the moves, writes an insert or append, then lists entries; an error beat
// follows the take. The store has one read and one write port, so entries are
// moved and listed one at a time. An issued result is registered in the read
// stage, then written into the result queue. A stalled result side fills a
// four-entry result queue, then the sequencer waits, then full rises.
// Reset (arst_n low) empties both queues and the store; entry contents are
// never read before they are written.
module positional_list_insert_delete_unit #(
	parameter int unsigned DEPTH = plh_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	input  logic               batch_end,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [31:0] element,
	output logic [5:0]         slot,
	output logic               last
);
	import plh_pkg::*;

	localparam int unsigned OW = $clog2(OQ_DEPTH+1);

	logic          accept;
	logic          cmd_vld;
	cmd_t          cmd;
	logic          cmd_full;
	logic          cmd_empty;
	cmd_t          cmd_head;
	logic          cmd_pop;
	logic          res_vld;
	res_t          res;
	res_t          oq_head;
	logic          oq_full;
	logic [OW-1:0] oq_count;

	assign accept = push && !cmd_full;
	assign full   = cmd_full;

	plh_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.position  (position),
		.value     (value),
		.batch_end (batch_end),
		.cmd_vld   (cmd_vld),
		.cmd       (cmd)
	);

	plh_fifo #(.T(cmd_t), .QDEPTH(CQ_DEPTH)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_vld),
		.wdata  (cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.count  ()
	);

	plh_back #(.DEPTH(DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_vld  (!cmd_empty),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.oq_count (oq_count),
		.res_vld  (res_vld),
		.res      (res)
	);

	plh_fifo #(.T(res_t), .QDEPTH(OQ_DEPTH)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_vld),
		.wdata  (res),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (oq_head),
		.empty  (empty),
		.count  (oq_count)
	);

	assign status  = oq_head.status;
	assign element = oq_head.element;
	assign slot    = oq_head.slot;
	assign last    = oq_head.last;

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_resq_no_overflow, clk, arst_n, res_vld, !oq_full, "result queue overrun")
	`ASSERT_IMPLIES(a_error_is_last, clk, arst_n, !empty && status != ST_ELEM, last, "single beat without last")
	`ASSERT_NEXT(a_one_cmd_at_a_time, clk, arst_n, cmd_pop, !cmd_pop, "command taken while busy")

endmodule

// File: src/plh_fifo.sv
module plh_fifo #(
	parameter type         T      = logic,
	parameter int unsigned QDEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             wdata,
	output logic                         full,
	input  logic                         pop,
	output T                             rdata,
	output logic                         empty,
	output logic [$clog2(QDEPTH+1)-1:0] count
);
	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned NW = $clog2(QDEPTH+1);

	T              mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == NW'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QDEPTH-1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QDEPTH-1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// File: src/plh_front.sv
module plh_front #(
	parameter int unsigned DEPTH = plh_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         opcode,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	input  logic               batch_end,
	output logic               cmd_vld,
	output plh_pkg::cmd_t      cmd
);
	import plh_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH+1);
	localparam int unsigned MW = (CW > 7) ? CW : 7;

	logic [CW-1:0] count_q;
	logic [MW-1:0] pos_x;
	logic [MW-1:0] cnt_x;
	logic          at_full;
	logic          grow;
	logic          shrink;

	assign pos_x   = MW'(position);
	assign cnt_x   = MW'(count_q);
	assign at_full = (count_q == CW'(DEPTH));

	// the shadow count runs ahead of the back end, so every beat is classified here
	always_comb begin
		cmd_vld   = accept;
		cmd.kind  = K_BOUNDS;
		cmd.pos   = position;
		cmd.value = value;
		cmd.list  = 1'b1;
		grow      = 1'b0;
		shrink    = 1'b0;
		unique case (opcode_t'(opcode))
			OP_INSERT: begin
				if (pos_x > cnt_x) begin
					cmd.kind = K_BOUNDS;
				end else if (at_full) begin
					cmd.kind = K_FULL;
				end else begin
					cmd.kind = K_INSERT;
					grow     = accept;
				end
			end
			OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					cmd.kind = K_BOUNDS;
				end else begin
					cmd.kind = K_DELETE;
					shrink   = accept;
				end
			end
			OP_APPEND: begin
				cmd.list = batch_end;
				if (at_full) begin
					cmd.kind = K_FULL;
				end else begin
					cmd.kind = K_APPEND;
					grow     = accept;
				end
			end
			OP_NONE: begin
				cmd_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (grow) begin
			count_q <= count_q + CW'(1);
		end else if (shrink) begin
			count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: src/plh_back.sv
module plh_back #(
	parameter int unsigned DEPTH = plh_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_vld,
	input  plh_pkg::cmd_t                          cmd,
	output logic                                   cmd_pop,
	input  logic [$clog2(plh_pkg::OQ_DEPTH+1)-1:0] oq_count,
	output logic                                   res_vld,
	output plh_pkg::res_t                          res
);
	import plh_pkg::*;

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned CW  = $clog2(DEPTH+1);
	localparam int unsigned OW  = $clog2(OQ_DEPTH+1);
	localparam int unsigned LIM = (DEPTH < LIST_MAX) ? DEPTH : LIST_MAX;

	bstate_t       state_q;
	bstate_t       state_d;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;

	logic          sh_vld_s1;
	logic [AW-1:0] sh_wa_s1;
	logic          res_vld_s1;
	logic          mem_s1;
	res_t          res_s1;

	logic [OW:0]   occ;
	logic          room;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] pos_qc;
	logic [CW-1:0] lim;
	logic          list_last;
	logic          re;
	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;
	logic          issue;
	logic          issue_mem;
	res_t          res_d;

	// credit: one result may still be in flight from the read stage
	assign occ       = (OW+1)'(oq_count) + (OW+1)'(res_vld_s1);
	assign room      = occ < (OW+1)'(OQ_DEPTH);
	assign pos_c     = CW'(cmd.pos);
	assign pos_qc    = CW'(cmd_q.pos);
	assign lim       = (count_q > CW'(LIM)) ? CW'(LIM) : count_q;
	assign list_last = (CW'(idx_q) + CW'(1)) == lim;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		re        = 1'b0;
		ra        = ptr_q;
		we        = sh_vld_s1;
		wa        = sh_wa_s1;
		wd        = rdata_q;
		issue     = 1'b0;
		issue_mem = 1'b0;
		res_d     = '{status: ST_ELEM, element: '0, slot: '0, last: 1'b1};
		unique case (state_q)
			B_IDLE: begin
				if (cmd_vld) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						K_INSERT: state_d = (count_q == pos_c) ? B_PUT : B_SHIFT;
						K_DELETE: state_d = (count_q - pos_c == CW'(1)) ? B_LIST : B_SHIFT;
						K_APPEND: state_d = B_PUT;
						default:  state_d = B_ONE;
					endcase
				end
			end
			B_SHIFT: begin
				re = 1'b1;
				if (rem_q == CW'(1)) begin
					state_d = (cmd_q.kind == K_INSERT) ? B_PUT : B_LIST;
				end
			end
			B_PUT: begin
				if (!sh_vld_s1) begin
					we      = 1'b1;
					wa      = (cmd_q.kind == K_INSERT) ? AW'(pos_qc) : AW'(count_q);
					wd      = cmd_q.value;
					state_d = cmd_q.list ? B_LIST : B_IDLE;
				end
			end
			B_LIST: begin
				if (!sh_vld_s1 && room) begin
					issue = 1'b1;
					if (count_q == '0) begin
						res_d.status = ST_EMPTY;
						state_d      = B_IDLE;
					end else begin
						re         = 1'b1;
						ra         = idx_q;
						issue_mem  = 1'b1;
						res_d.slot = 6'(idx_q);
						res_d.last = list_last;
						if (list_last) begin
							state_d = B_IDLE;
						end
					end
				end
			end
			B_ONE: begin
				if (room) begin
					issue        = 1'b1;
					res_d.status = (cmd_q.kind == K_FULL) ? ST_FULL : ST_BOUNDS;
					state_d      = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			count_q    <= '0;
			sh_vld_s1  <= 1'b0;
			res_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			sh_vld_s1  <= (state_q == B_SHIFT);
			res_vld_s1 <= issue;
			if (state_q == B_IDLE && cmd_vld && cmd.kind == K_DELETE) begin
				count_q <= count_q - CW'(1);
			end else if (state_q == B_PUT && !sh_vld_s1) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_vld) begin
			cmd_q <= cmd;
			if (cmd.kind == K_INSERT) begin
				ptr_q <= AW'(count_q - CW'(1));
				rem_q <= count_q - pos_c;
			end else begin
				ptr_q <= AW'(pos_c + CW'(1));
				rem_q <= count_q - pos_c - CW'(1);
			end
		end else if (state_q == B_SHIFT) begin
			rem_q <= rem_q - CW'(1);
			if (cmd_q.kind == K_INSERT) begin
				ptr_q    <= ptr_q - AW'(1);
				sh_wa_s1 <= ptr_q + AW'(1);
			end else begin
				ptr_q    <= ptr_q + AW'(1);
				sh_wa_s1 <= ptr_q - AW'(1);
			end
		end
		if (state_q != B_LIST) begin
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= idx_q + AW'(1);
		end
		if (issue) begin
			res_s1 <= res_d;
			mem_s1 <= issue_mem;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	always_comb begin
		res_vld     = res_vld_s1;
		res         = res_s1;
		res.element = mem_s1 ? rdata_q : '0;
	end

endmodule
